[sv/tile_grid_box_collision_defines.svh]
// Assertion macros used by the checker file of the tile grid box collision block.
`ifndef TILE_GRID_BOX_COLLISION_DEFINES_SVH
`define TILE_GRID_BOX_COLLISION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TGBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked across reset.
`define TGBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/tgbc_pkg.sv]
// Package with shared types and constants of the tile grid box collision block.
`default_nettype none
package tgbc_pkg;
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int STORE_SIZE  = MAX_COLUMNS * MAX_ROWS;
    localparam int IDX_W       = 12;
    localparam int WORD_W      = 64;
    localparam int BIT_W       = 6;
    localparam int WADDR_W     = IDX_W - BIT_W;
    localparam int NWORDS      = STORE_SIZE / WORD_W;
    localparam int CNT_W       = 7;
    localparam int POS_W       = 6;
    localparam int ACC_W       = 40;
    localparam int DIFF_W      = 33;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [2:0] CFG_MIN_X   = 3'd0;
    localparam logic [2:0] CFG_MIN_Y   = 3'd1;
    localparam logic [2:0] CFG_MAX_X   = 3'd2;
    localparam logic [2:0] CFG_MAX_Y   = 3'd3;
    localparam logic [2:0] CFG_COLUMNS = 3'd4;
    localparam logic [2:0] CFG_ROWS    = 3'd5;
    localparam logic [2:0] CFG_ENABLE  = 3'd6;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  tile_index;
        logic              tile_solid;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
    } t_item;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic [CNT_W-1:0]   cols;
        logic [CNT_W-1:0]   rows;
        logic               enabled;
    } t_cfg;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_XMASK = 6'b001000,
        S_ROWS  = 6'b010000,
        S_LAST  = 6'b100000
    } t_state;
endpackage
`default_nettype wire

[sv/tgbc_div.sv]
// Bit-serial signed divider of a 33-bit difference by a small unsigned count.
`default_nettype none
module tgbc_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic signed [tgbc_pkg::DIFF_W-1:0] i_dividend,
    input  wire logic [tgbc_pkg::CNT_W-1:0]       i_divisor,
    output logic                                  o_done,
    output logic signed [tgbc_pkg::DIFF_W-1:0]    o_quotient
);
    import tgbc_pkg::*;

    logic              r_busy;
    logic [5:0]        r_cnt;
    logic              r_neg;
    logic [CNT_W:0]    r_rem;
    logic [DIFF_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_div;
    logic              r_done;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_sub;
    logic              ge;

    always_comb begin
        rem_sh  = {r_rem[CNT_W-1:0], r_quo[DIFF_W-1]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_dividend[DIFF_W-1];
                r_quo  <= i_dividend[DIFF_W-1] ? DIFF_W'(-i_dividend) : i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub : rem_sh;
                r_quo <= {r_quo[DIFF_W-2:0], ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIFF_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? $signed(DIFF_W'(-r_quo)) : $signed(r_quo);
endmodule
`default_nettype wire

[sv/tgbc_front.sv]
// Front end: accepts transactions and holds them in a two-entry queue.
`default_nettype none
module tgbc_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire tgbc_pkg::t_item        i_item,
    input  wire tgbc_pkg::t_back_status i_status,
    input  wire logic                   i_pop,
    output logic                        o_busy,
    output logic                        o_valid,
    output tgbc_pkg::t_item             o_item
);
    import tgbc_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_busy  = (r_cnt == 2'd2) || i_status.clearing;
    assign push    = i_start && !o_busy;
    assign o_valid = r_cnt != 2'd0;
    assign pop     = i_pop && o_valid;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

[sv/tgbc_back.sv]
// Back end: tile store, stride division, column mask and row scan for queries.
`default_nettype none
module tgbc_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire tgbc_pkg::t_cfg         i_cfg,
    input  wire logic                   i_item_valid,
    input  wire tgbc_pkg::t_item        i_item,
    output logic                        o_pop,
    output tgbc_pkg::t_back_status      o_status,
    output logic                        o_valid,
    output logic                        o_hit
);
    import tgbc_pkg::*;

    t_state r_state;
    logic [WORD_W-1:0] r_mem [NWORDS];
    logic [WORD_W-1:0] r_rd0;
    logic [WORD_W-1:0] r_rd1;
    logic [WADDR_W-1:0] r_clr;

    logic signed [ACC_W-1:0] r_ox0, r_oy0, r_ox1, r_oy1;
    logic signed [DIFF_W-1:0] r_sx, r_sy;
    logic signed [ACC_W-1:0] r_tx0, r_ty0;
    logic [POS_W-1:0] r_c, r_r;
    logic [WORD_W-1:0] r_mask;
    logic [IDX_W-1:0] r_base;
    logic r_p_valid, r_p_ok, r_acc;
    logic [BIT_W-1:0] r_p_off;
    logic r_div_start, r_out_valid, r_out_hit;

    logic div_x_done, div_y_done;
    logic signed [DIFF_W-1:0] qx, qy;
    logic signed [DIFF_W-1:0] diff_x, diff_y;
    logic signed [ACC_W-1:0] sx_e, sy_e, tx1, ty1;
    logic x_ok, y_ok, row_hit;
    logic [2*WORD_W-1:0] window;
    logic [WADDR_W-1:0] ra0, ra1;
    logic mem_wr;

    assign diff_x = $signed({i_cfg.max_x[31], i_cfg.max_x})
                  - $signed({i_cfg.min_x[31], i_cfg.min_x});
    assign diff_y = $signed({i_cfg.max_y[31], i_cfg.max_y})
                  - $signed({i_cfg.min_y[31], i_cfg.min_y});

    tgbc_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_dividend(diff_x), .i_divisor(i_cfg.cols),
        .o_done(div_x_done), .o_quotient(qx)
    );

    tgbc_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_dividend(diff_y), .i_divisor(i_cfg.rows),
        .o_done(div_y_done), .o_quotient(qy)
    );

    always_comb begin
        sx_e    = ACC_W'(r_sx);
        sy_e    = ACC_W'(r_sy);
        tx1     = r_tx0 + sx_e;
        ty1     = r_ty0 + sy_e;
        x_ok    = (r_ox0 <= tx1) && (r_tx0 <= r_ox1);
        y_ok    = (r_oy0 <= ty1) && (r_ty0 <= r_oy1);
        window  = {r_rd1, r_rd0} >> r_p_off;
        row_hit = r_p_valid && r_p_ok && (|(window[WORD_W-1:0] & r_mask));
        ra0     = r_base[IDX_W-1:BIT_W];
        ra1     = ra0 + WADDR_W'(1);
        o_pop   = (r_state == S_IDLE);
        mem_wr  = o_pop && i_item_valid && (i_item.mode == MODE_WRITE);
    end

    assign o_status.clearing = (r_state == S_CLEAR);

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem[r_clr] <= '0;
        end else if (mem_wr) begin
            r_mem[i_item.tile_index[IDX_W-1:BIT_W]][i_item.tile_index[BIT_W-1:0]]
                <= i_item.tile_solid;
        end
        r_rd0 <= r_mem[ra0];
        r_rd1 <= r_mem[ra1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_hit   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + WADDR_W'(1);
                    if (r_clr == WADDR_W'(NWORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_item_valid && i_item.mode == MODE_QUERY) begin
                        if (!i_cfg.enabled) begin
                            r_out_valid <= 1'b1;
                            r_out_hit   <= 1'b0;
                        end else begin
                            r_ox0 <= ACC_W'(i_item.min_x);
                            r_oy0 <= ACC_W'(i_item.min_y);
                            r_ox1 <= ACC_W'(i_item.max_x);
                            r_oy1 <= ACC_W'(i_item.max_y);
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_x_done && div_y_done) begin
                        r_sx    <= qx;
                        r_sy    <= qy;
                        r_tx0   <= ACC_W'(i_cfg.min_x);
                        r_c     <= '0;
                        r_mask  <= '0;
                        r_state <= S_XMASK;
                    end
                end
                S_XMASK: begin
                    r_mask[r_c] <= x_ok;
                    r_tx0 <= tx1;
                    r_c   <= r_c + POS_W'(1);
                    if ({1'b0, r_c} == i_cfg.cols - CNT_W'(1)) begin
                        r_ty0     <= ACC_W'(i_cfg.min_y);
                        r_r       <= '0;
                        r_base    <= '0;
                        r_p_valid <= 1'b0;
                        r_acc     <= 1'b0;
                        r_state   <= S_ROWS;
                    end
                end
                S_ROWS: begin
                    r_p_valid <= 1'b1;
                    r_p_ok    <= y_ok;
                    r_p_off   <= r_base[BIT_W-1:0];
                    r_acc     <= r_acc | row_hit;
                    r_ty0     <= ty1;
                    r_base    <= r_base + IDX_W'(i_cfg.cols);
                    r_r       <= r_r + POS_W'(1);
                    if ({1'b0, r_r} == i_cfg.rows - CNT_W'(1)) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_out_valid <= 1'b1;
                    r_out_hit   <= r_acc | row_hit;
                    r_p_valid   <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_hit   = r_out_hit & r_out_valid;
endmodule
`default_nettype wire

[sv/tile_grid_box_collision.sv]
// Top level of the tile grid box collision block: configuration registers and the two halves.
// A write transaction gives no result; the back end stores its tile bit in the same cycle
// as it leaves the queue. A query with collision disabled gives its miss in the cycle after
// it leaves the queue. An enabled query runs through the 33-step serial stride dividers,
// then builds one column of the hit mask per cycle and reads one bitmap row per cycle. Up
// to two transactions wait in the queue; busy is high while it is full. After reset a
// clearing pass over the 64 words of the tile store also holds busy high. Results appear
// for one cycle on o_valid and o_hit and cannot be stalled.
`default_nettype none
module tile_grid_box_collision (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic                         i_mode,
    input  wire logic [tgbc_pkg::IDX_W-1:0]   i_tile_index,
    input  wire logic                         i_tile_solid,
    input  wire logic signed [31:0]           i_obj_min_x,
    input  wire logic signed [31:0]           i_obj_min_y,
    input  wire logic signed [31:0]           i_obj_max_x,
    input  wire logic signed [31:0]           i_obj_max_y,
    output logic                              o_valid,
    output logic                              o_hit,
    input  wire logic                         i_cfg_we,
    input  wire logic [2:0]                   i_cfg_idx,
    input  wire logic [31:0]                  i_cfg_data
);
    import tgbc_pkg::*;

    logic signed [31:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic [CNT_W-1:0]   r_cols, r_rows;
    logic               r_en;
    t_cfg               cfg;
    t_item              in_item, q_item;
    t_back_status       status;
    logic               q_valid, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_min_y <= '0;
            r_max_x <= 32'sd65536;
            r_max_y <= 32'sd65536;
            r_cols  <= CNT_W'(1);
            r_rows  <= CNT_W'(1);
            r_en    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_X:   r_min_x <= i_cfg_data;
                CFG_MIN_Y:   r_min_y <= i_cfg_data;
                CFG_MAX_X:   r_max_x <= i_cfg_data;
                CFG_MAX_Y:   r_max_y <= i_cfg_data;
                CFG_COLUMNS: r_cols  <= i_cfg_data[CNT_W-1:0];
                CFG_ROWS:    r_rows  <= i_cfg_data[CNT_W-1:0];
                CFG_ENABLE:  r_en    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.min_x   = r_min_x;
        cfg.min_y   = r_min_y;
        cfg.max_x   = r_max_x;
        cfg.max_y   = r_max_y;
        cfg.enabled = r_en;
        cfg.cols = (r_cols == '0) ? CNT_W'(1)
                 : (r_cols > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : r_cols;
        cfg.rows = (r_rows == '0) ? CNT_W'(1)
                 : (r_rows > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : r_rows;
        in_item.mode       = i_mode;
        in_item.tile_index = i_tile_index;
        in_item.tile_solid = i_tile_solid;
        in_item.min_x      = i_obj_min_x;
        in_item.min_y      = i_obj_min_y;
        in_item.max_x      = i_obj_max_x;
        in_item.max_y      = i_obj_max_y;
    end

    tgbc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(in_item),
        .i_status(status), .i_pop(pop), .o_busy(o_busy),
        .o_valid(q_valid), .o_item(q_item)
    );

    tgbc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg), .i_item_valid(q_valid),
        .i_item(q_item), .o_pop(pop), .o_status(status),
        .o_valid(o_valid), .o_hit(o_hit)
    );
endmodule
`default_nettype wire

[sv/tgbc_checker.sv]
// Port-level checker of the tile grid box collision block and its bind statement.
`default_nettype none
`include "tile_grid_box_collision_defines.svh"
module tgbc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_valid,
    input wire logic o_hit
);
    `TGBC_ASSERT_NOW(a_hit_needs_valid, o_hit, o_valid, "hit shown without a result")
    `TGBC_ASSERT_NOW(a_handshake_known, 1'b1, !$isunknown({i_start, o_busy}), "handshake unknown")
    `TGBC_ASSERT_NEXT(a_no_result_after_reset, !i_rst_n, !o_valid, "result right after reset")
    `TGBC_ASSERT_NEXT(a_busy_while_clearing, !i_rst_n, o_busy, "not busy during clearing")
endmodule

bind tile_grid_box_collision tgbc_checker u_tgbc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
    .o_busy(o_busy), .o_valid(o_valid), .o_hit(o_hit)
);
`default_nettype wire
